// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and line tables shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int PHASE_TICKS_W = 8;
  localparam int RETRY_W       = 4;
  localparam int PHASE_W       = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST = 8'd2;
  localparam logic [RETRY_W-1:0]       ACK_RETRIES_RST = 4'd5;

  // item kinds
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_RETRIES = 1'd1;

  // phase landmarks
  localparam logic [PHASE_W-1:0] PH_FRAME_LAST = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ACK_WAIT   = 5'd16;
  localparam logic [PHASE_W-1:0] PH_ACK_DONE   = 5'd17;
  localparam logic [PHASE_W-1:0] PH_STOP0      = 5'd18;
  localparam logic [PHASE_W-1:0] PH_STOP_LAST  = 5'd20;
  localparam logic [PHASE_W-1:0] PH_RD_ACK_LAST = 5'd18;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
  } lines_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
  } result_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [PHASE_W-1:0]        phase;
    logic [PHASE_TICKS_W-1:0]  tick;
    logic [7:0]                shift;
    logic [RETRY_W-1:0]        retry;
    logic                      ack_choice;
    lines_t                    lines;
    logic [7:0]                held_read;
    logic                      held_ack;
  } state_t;

  localparam lines_t LINES_RST = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};

  function automatic lines_t stop_lines(input logic [PHASE_W-1:0] p);
    lines_t l;
    if (p == 5'd0) begin
      l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
    end else if (p == 5'd1) begin
      l = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
    end else begin
      l = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
    end
    return l;
  endfunction

  // line levels for a command and phase
  function automatic lines_t phase_lines(input cmd_t cmd, input logic [PHASE_W-1:0] p,
                                         input logic [7:0] shift, input logic ack_choice,
                                         input lines_t cur);
    lines_t l;
    logic [2:0] bit_sel;
    l = cur;
    bit_sel = 3'd7 - p[3:1];
    case (cmd)
      CMD_START: begin
        if (p == 5'd0) begin
          l = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
        end else if (p == 5'd1) begin
          l = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
        end else begin
          l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
        end
      end
      CMD_STOP: begin
        l = stop_lines(p);
      end
      CMD_WRITE: begin
        if (p < PH_ACK_WAIT) begin
          l = '{scl: p[0], sda: shift[bit_sel], drive: 1'b1};
        end else if (p == PH_ACK_WAIT) begin
          l = '{scl: 1'b1, sda: 1'b1, drive: 1'b0};
        end else if (p == PH_ACK_DONE) begin
          l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
        end else begin
          l = stop_lines(p - PH_STOP0);
        end
      end
      CMD_READ: begin
        if (p < PH_ACK_WAIT) begin
          l = '{scl: p[0], sda: 1'b1, drive: 1'b0};
        end else begin
          l = '{scl: (p == PH_ACK_DONE), sda: ~ack_choice, drive: 1'b1};
        end
      end
      default: begin
        l = cur;
      end
    endcase
    return l;
  endfunction

endpackage

// File: rtl/i2cm_cmd_if.sv
// ----------------------------------------------------------------------------
// i2cm_cmd_if
// Command and tick channel into the engine.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_sample;

  modport source (output valid, kind, write_data, send_ack, sda_sample, input ready);
  modport sink (input valid, kind, write_data, send_ack, sda_sample, output ready);
endinterface

// File: rtl/i2cm_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Result channel out of the engine: bus lines and status.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_received;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_received, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                read_data, ack_received, output ready);
endinterface

// File: rtl/i2cm_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/i2c_master_byte_engine.sv
// an accepted item passes through the input register and then the result register; the
// result register loads only while it is empty or its result is being taken
// throughput: one item per clock without a result stall; the sequencer state register advances once per item
// under a result stall the input register takes one more item, then cmd.ready drops
// reset (rst, synchronous): engine idle, SCL and SDA high and driven, held read byte and
// ack result zero, phase_ticks 2, ack_retries 5
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Tick-paced I2C master: start, stop, write byte and read byte commands.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter logic [PHASE_TICKS_W-1:0] PHASE_TICKS_INIT = PHASE_TICKS_RST,
  parameter logic [RETRY_W-1:0]       ACK_RETRIES_INIT = ACK_RETRIES_RST
) (
  input  logic         clk,
  input  logic         rst,
  i2cm_cmd_if.sink     cmd,
  i2cm_rsp_if.source   rsp,
  i2cm_cfg_if.sink     cfg
);

  logic [PHASE_TICKS_W-1:0] phase_ticks;
  logic [RETRY_W-1:0]       ack_retries;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  state_t  state;
  state_t  state_next;
  result_t step_result;
  logic    advance;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_INIT;
      ack_retries <= ACK_RETRIES_INIT;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PHASE_TICKS) begin
        phase_ticks <= cfg.data;
      end else if (cfg.index == REG_ACK_RETRIES) begin
        ack_retries <= cfg.data[RETRY_W-1:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_item <= '{kind: cmd.kind, write_data: cmd.write_data,
                   send_ack: cmd.send_ack, sda_sample: cmd.sda_sample};
    end
  end

  i2cm_step u_step (
    .state       (state),
    .item        (in_item),
    .phase_ticks (phase_ticks),
    .ack_retries (ack_retries),
    .state_next  (state_next),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{cmd: CMD_IDLE, phase: '0, tick: '0, shift: '0, retry: '0,
                 ack_choice: 1'b0, lines: LINES_RST, held_read: '0, held_ack: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.scl_level    = out_result.scl_level;
  assign rsp.sda_level    = out_result.sda_level;
  assign rsp.sda_drive    = out_result.sda_drive;
  assign rsp.busy_res     = out_result.busy_res;
  assign rsp.done_res     = out_result.done_res;
  assign rsp.read_data    = out_result.read_data;
  assign rsp.ack_received = out_result.ack_received;

endmodule

// File: rtl/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// One sequencer step: next engine state and result for one item.
// ----------------------------------------------------------------------------
module i2cm_step
  import i2cm_pkg::*;
(
  input  state_t                   state,
  input  item_t                    item,
  input  logic [PHASE_TICKS_W-1:0] phase_ticks,
  input  logic [RETRY_W-1:0]       ack_retries,
  output state_t                   state_next,
  output result_t                  result
);

  logic [PHASE_TICKS_W-1:0] tick_limit;
  logic [RETRY_W-1:0]       retry_limit;
  logic [PHASE_TICKS_W-1:0] tick_inc;
  logic [RETRY_W-1:0]       retry_inc;
  logic [PHASE_W-1:0]       phase_inc;
  logic                     done;

  assign tick_limit  = (phase_ticks == '0) ? PHASE_TICKS_W'(1) : phase_ticks;
  assign retry_limit = (ack_retries == '0) ? RETRY_W'(1) : ack_retries;
  assign tick_inc    = state.tick + PHASE_TICKS_W'(1);
  assign retry_inc   = state.retry + RETRY_W'(1);
  assign phase_inc   = state.phase + PHASE_W'(1);

  always_comb begin
    state_next = state;
    done       = 1'b0;
    if (item.kind == KIND_TICK) begin
      if (state.cmd != CMD_IDLE) begin
        if (tick_inc < tick_limit) begin
          state_next.tick = tick_inc;
        end else begin
          state_next.tick = '0;
          // end of phase
          case (state.cmd)
            CMD_START, CMD_STOP: begin
              if (state.phase >= PH_FRAME_LAST) begin
                done = 1'b1;
              end else begin
                state_next.phase = phase_inc;
              end
            end
            CMD_WRITE: begin
              if (state.phase < PH_ACK_WAIT) begin
                state_next.phase = phase_inc;
                if (phase_inc == PH_ACK_WAIT) begin
                  state_next.retry = '0;
                end
              end else if (state.phase == PH_ACK_WAIT) begin
                if (!item.sda_sample) begin
                  state_next.phase = PH_ACK_DONE;
                end else begin
                  state_next.retry = retry_inc;
                  if (retry_inc >= retry_limit) begin
                    state_next.phase = PH_STOP0;
                  end
                end
              end else if (state.phase == PH_ACK_DONE) begin
                state_next.held_ack = 1'b1;
                done = 1'b1;
              end else if (state.phase >= PH_STOP_LAST) begin
                state_next.held_ack = 1'b0;
                done = 1'b1;
              end else begin
                state_next.phase = phase_inc;
              end
            end
            CMD_READ: begin
              if (state.phase < PH_ACK_WAIT && state.phase[0]) begin
                state_next.shift = {state.shift[6:0], item.sda_sample};
              end
              if (state.phase >= PH_RD_ACK_LAST) begin
                state_next.held_read = state_next.shift;
                done = 1'b1;
              end else begin
                state_next.phase = phase_inc;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
          if (done) begin
            state_next.cmd   = CMD_IDLE;
            state_next.phase = '0;
            state_next.tick  = '0;
          end else begin
            state_next.lines = phase_lines(state_next.cmd, state_next.phase,
                                           state_next.shift, state_next.ack_choice,
                                           state.lines);
          end
        end
      end
    end else if (item.kind <= KIND_READ && state.cmd == CMD_IDLE) begin
      // new command, kind codes match the command codes
      state_next.cmd   = cmd_t'(item.kind);
      state_next.phase = '0;
      state_next.tick  = '0;
      state_next.retry = '0;
      if (cmd_t'(item.kind) == CMD_WRITE) begin
        state_next.shift = item.write_data;
      end
      if (cmd_t'(item.kind) == CMD_READ) begin
        state_next.shift      = '0;
        state_next.ack_choice = item.send_ack;
      end
      state_next.lines = phase_lines(state_next.cmd, state_next.phase, state_next.shift,
                                     state_next.ack_choice, state.lines);
    end
  end

  always_comb begin
    result.scl_level    = state_next.lines.scl;
    result.sda_level    = state_next.lines.sda;
    result.sda_drive    = state_next.lines.drive;
    result.busy_res     = (state_next.cmd != CMD_IDLE);
    result.done_res     = done;
    result.read_data    = state_next.held_read;
    result.ack_received = state_next.held_ack;
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tick-paced I2C master byte engine. Commands and
// ticks go in on the command channel; a shadow of the engine computes the
// line levels and status that each item should produce, and every result is
// compared in order against it. Directed tests cover the bus frames, write
// ACK and NACK paths, reads, busy and unused commands and the register
// extremes; random transactions with random idling on both sides follow.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam logic [2:0] KIND_STOP       = 3'd2;
  localparam logic [2:0] KIND_WRITE      = 3'd3;
  localparam logic [2:0] KIND_SPARE_LO   = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI   = 3'd7;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         RANDOM_ITEMS    = 100;
  localparam int         IDLE_PCT        = 19;
  localparam int         MAX_REPORTS     = 10;
  localparam int         DRAIN_CYCLES    = 8;

  logic clk;
  logic rst;

  i2cm_cmd_if cmd_ch ();
  i2cm_rsp_if rsp_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_byte_engine DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // shadow of the engine
  cmd_t                     eng_cmd;
  logic [PHASE_W-1:0]       eng_phase;
  logic [PHASE_TICKS_W-1:0] eng_ticks;
  logic [7:0]               eng_shift;
  logic [RETRY_W-1:0]       eng_retry;
  logic                     eng_ack_sel;
  lines_t                   eng_lines;
  logic [7:0]               eng_rd_byte;
  logic                     eng_ack_flag;
  logic [PHASE_TICKS_W-1:0] cfg_phase_ticks;
  logic [RETRY_W-1:0]       cfg_ack_retries;

  result_t line_status_q[$];
  int      cycles = 0;
  int      mismatches = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  bit      jitter_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lines_t stop_levels(input logic [PHASE_W-1:0] p);
    if (p == 5'd0) begin
      return '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
    end else if (p == 5'd1) begin
      return '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
    end
    return '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
  endfunction

  // levels for the current command and phase
  function automatic lines_t bus_levels();
    lines_t l;
    l = eng_lines;
    case (eng_cmd)
      CMD_START: begin
        if (eng_phase == 5'd0) begin
          l = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
        end else if (eng_phase == 5'd1) begin
          l = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
        end else begin
          l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
        end
      end
      CMD_STOP: begin
        l = stop_levels(eng_phase);
      end
      CMD_WRITE: begin
        if (eng_phase < PH_ACK_WAIT) begin
          l = '{scl: eng_phase[0], sda: eng_shift[3'd7 - eng_phase[3:1]], drive: 1'b1};
        end else if (eng_phase == PH_ACK_WAIT) begin
          l = '{scl: 1'b1, sda: 1'b1, drive: 1'b0};
        end else if (eng_phase == PH_ACK_DONE) begin
          l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
        end else begin
          l = stop_levels(eng_phase - PH_STOP0);
        end
      end
      CMD_READ: begin
        if (eng_phase < PH_ACK_WAIT) begin
          l = '{scl: eng_phase[0], sda: 1'b1, drive: 1'b0};
        end else begin
          l = '{scl: (eng_phase == PH_ACK_DONE), sda: ~eng_ack_sel, drive: 1'b1};
        end
      end
      default: begin
        l = eng_lines;
      end
    endcase
    return l;
  endfunction

  // end of a phase: sample, advance, report whether the command is over
  function automatic bit phase_close(input logic sda);
    logic [RETRY_W-1:0] tries;
    bit                 over;
    tries = (cfg_ack_retries == '0) ? 4'd1 : cfg_ack_retries;
    over  = 1'b0;
    case (eng_cmd)
      CMD_START, CMD_STOP: begin
        if (eng_phase >= PH_FRAME_LAST) begin
          over = 1'b1;
        end else begin
          eng_phase = eng_phase + 1'b1;
        end
      end
      CMD_WRITE: begin
        if (eng_phase < PH_ACK_WAIT) begin
          eng_phase = eng_phase + 1'b1;
          if (eng_phase == PH_ACK_WAIT) begin
            eng_retry = '0;
          end
        end else if (eng_phase == PH_ACK_WAIT) begin
          if (sda == 1'b0) begin
            eng_phase = PH_ACK_DONE;
          end else begin
            eng_retry = eng_retry + 1'b1;
            if (eng_retry >= tries) begin
              eng_phase = PH_STOP0;
            end
          end
        end else if (eng_phase == PH_ACK_DONE) begin
          eng_ack_flag = 1'b1;
          over = 1'b1;
        end else if (eng_phase >= PH_STOP_LAST) begin
          eng_ack_flag = 1'b0;
          over = 1'b1;
        end else begin
          eng_phase = eng_phase + 1'b1;
        end
      end
      CMD_READ: begin
        // data bits are taken at the end of each scl-high phase
        if (eng_phase < PH_ACK_WAIT && eng_phase[0]) begin
          eng_shift = {eng_shift[6:0], sda};
        end
        if (eng_phase >= PH_RD_ACK_LAST) begin
          eng_rd_byte = eng_shift;
          over = 1'b1;
        end else begin
          eng_phase = eng_phase + 1'b1;
        end
      end
      default: begin
        over = 1'b1;
      end
    endcase
    return over;
  endfunction

  function automatic result_t engine_step(input item_t it);
    result_t                  r;
    logic [PHASE_TICKS_W-1:0] lim;
    logic                     fin;
    fin = 1'b0;
    if (it.kind == KIND_TICK) begin
      if (eng_cmd != CMD_IDLE) begin
        lim = (cfg_phase_ticks == '0) ? 8'd1 : cfg_phase_ticks;
        eng_ticks = eng_ticks + 1'b1;
        if (eng_ticks >= lim) begin
          eng_ticks = '0;
          if (phase_close(it.sda_sample)) begin
            eng_cmd   = CMD_IDLE;
            eng_phase = '0;
            fin       = 1'b1;
          end else begin
            eng_lines = bus_levels();
          end
        end
      end
    end else if (it.kind <= KIND_READ && eng_cmd == CMD_IDLE) begin
      eng_cmd   = cmd_t'(it.kind);
      eng_phase = '0;
      eng_ticks = '0;
      eng_retry = '0;
      if (it.kind == KIND_WRITE) begin
        eng_shift = it.write_data;
      end
      if (it.kind == KIND_READ) begin
        eng_shift   = '0;
        eng_ack_sel = it.send_ack;
      end
      eng_lines = bus_levels();
    end
    r.scl_level    = eng_lines.scl;
    r.sda_level    = eng_lines.sda;
    r.sda_drive    = eng_lines.drive;
    r.busy_res     = (eng_cmd != CMD_IDLE);
    r.done_res     = fin;
    r.read_data    = eng_rd_byte;
    r.ack_received = eng_ack_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= jitter_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // shadow update on accepted items and writes, result check in order
  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      eng_cmd         = CMD_IDLE;
      eng_phase       = '0;
      eng_ticks       = '0;
      eng_shift       = '0;
      eng_retry       = '0;
      eng_ack_sel     = 1'b0;
      eng_lines       = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
      eng_rd_byte     = '0;
      eng_ack_flag    = 1'b0;
      cfg_phase_ticks = 8'd2;
      cfg_ack_retries = 4'd5;
      line_status_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_PHASE_TICKS) begin
          cfg_phase_ticks = cfg_ch.data;
        end else if (cfg_ch.index == REG_ACK_RETRIES) begin
          cfg_ack_retries = cfg_ch.data[RETRY_W-1:0];
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        it.kind       = cmd_ch.kind;
        it.write_data = cmd_ch.write_data;
        it.send_ack   = cmd_ch.send_ack;
        it.sda_sample = cmd_ch.sda_sample;
        line_status_q.push_back(engine_step(it));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.scl_level    = rsp_ch.scl_level;
        got.sda_level    = rsp_ch.sda_level;
        got.sda_drive    = rsp_ch.sda_drive;
        got.busy_res     = rsp_ch.busy_res;
        got.done_res     = rsp_ch.done_res;
        got.read_data    = rsp_ch.read_data;
        got.ack_received = rsp_ch.ack_received;
        results_seen++;
        if (line_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d arrived with nothing pending: %p", results_seen, got);
          end
        end else begin
          want = line_status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: exp scl=%b sda=%b drv=%b busy=%b done=%b rd=%h ack=%b",
                       results_seen, want.scl_level, want.sda_level, want.sda_drive,
                       want.busy_res, want.done_res, want.read_data, want.ack_received);
              $display("result %0d: got scl=%b sda=%b drv=%b busy=%b done=%b rd=%h ack=%b",
                       results_seen, got.scl_level, got.sda_level, got.sda_drive,
                       got.busy_res, got.done_res, got.read_data, got.ack_received);
            end
          end
        end
      end
    end
  end

  task automatic push_item(input logic [2:0] kind, input logic [7:0] wdata,
                           input logic sack, input logic sda);
    while (jitter_on && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= kind;
    cmd_ch.write_data <= wdata;
    cmd_ch.send_ack   <= sack;
    cmd_ch.sda_sample <= sda;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // ticks until the command ends; zero_pct biases sda low (ack), noise_pct
  // mixes in commands that a busy engine must ignore
  task automatic run_to_idle(input int zero_pct, input int noise_pct);
    while (eng_cmd != CMD_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_item(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        push_item(KIND_TICK, 8'($urandom), 1'($urandom),
                  ($urandom_range(0, 99) < zero_pct) ? 1'b0 : 1'b1);
      end
    end
  endtask

  task automatic run_cmd(input logic [2:0] kind, input logic [7:0] wdata,
                         input logic sack, input int zero_pct);
    push_item(kind, wdata, sack, 1'($urandom));
    run_to_idle(zero_pct, 0);
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (line_status_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] ticks, input logic [3:0] tries);
    run_to_idle(50, 0);
    settle();
    cfg_write(REG_PHASE_TICKS, ticks);
    // upper bits of the retry write are don't-care
    cfg_write(REG_ACK_RETRIES, {4'($urandom), tries});
  endtask

  task automatic test_idle_lines();
    repeat (4) push_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      push_item(3'(k), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_bus_frames();
    run_cmd(KIND_START, 8'h00, 1'b0, 50);
    run_cmd(KIND_STOP, 8'hFF, 1'b1, 50);
  endtask

  task automatic test_write_byte();
    run_cmd(KIND_WRITE, 8'hA5, 1'b0, 100);
    run_cmd(KIND_WRITE, 8'h00, 1'b1, 0);
  endtask

  task automatic test_read_byte();
    run_cmd(KIND_READ, 8'h00, 1'b1, 0);
    run_cmd(KIND_READ, 8'hFF, 1'b0, 100);
  endtask

  task automatic test_busy_commands();
    push_item(KIND_START, 8'h00, 1'b0, 1'b1);
    push_item(KIND_WRITE, 8'hC3, 1'b1, 1'b0);
    push_item(KIND_TICK, 8'h00, 1'b0, 1'b1);
    push_item(KIND_READ, 8'h3C, 1'b0, 1'b1);
    push_item(KIND_STOP, 8'hFF, 1'b1, 1'b0);
    push_item(KIND_START, 8'h00, 1'b0, 1'b0);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      push_item(3'(k), 8'($urandom), 1'($urandom), 1'($urandom));
    end
    run_to_idle(50, 20);
  endtask

  task automatic test_register_extremes();
    // zero means one tick per phase and a single ack sample
    set_config(8'd0, 4'd0);
    run_cmd(KIND_WRITE, 8'h81, 1'b0, 0);
    run_cmd(KIND_READ, 8'h00, 1'b0, 50);
    set_config(8'd1, 4'd1);
    run_cmd(KIND_WRITE, 8'h7E, 1'b0, 0);
    // long phases: part of a phase at 255, then a lower limit ends it on the next tick
    set_config(8'd255, 4'd15);
    push_item(KIND_START, 8'h00, 1'b0, 1'b1);
    repeat (8) push_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    settle();
    cfg_write(REG_PHASE_TICKS, 8'd1);
    run_to_idle(50, 0);
    run_cmd(KIND_WRITE, 8'hE7, 1'b0, 0);
    set_config(8'd2, 4'd5);
  endtask

  task automatic test_random_traffic();
    int base;
    int done_items;
    int nbytes;
    int zero_pct;
    base = items_sent;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      // first transaction runs with no idling on either side
      jitter_on = (done_items != 0);
      if (done_items != 0 && $urandom_range(0, 4) == 0) begin
        set_config(($urandom_range(0, 9) == 0) ? 8'd0 :
                   ($urandom_range(0, 9) == 0) ? 8'd3 :
                   8'($urandom_range(1, 2)),
                   4'($urandom_range(0, 15)));
      end
      if (done_items == 0 || $urandom_range(0, 99) < 85) begin
        push_item(KIND_START, 8'($urandom), 1'($urandom), 1'($urandom));
        run_to_idle(50, 3);
        nbytes = $urandom_range(1, 2);
        repeat (nbytes) begin
          zero_pct = ($urandom_range(0, 3) == 0) ? 0 : 50;
          push_item(($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ,
                    8'($urandom), 1'($urandom), 1'($urandom));
          run_to_idle(zero_pct, 3);
        end
        if ($urandom_range(0, 9) != 0) begin
          push_item(KIND_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
          run_to_idle(50, 3);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
        end
        run_to_idle(50, 10);
      end
      done_items = items_sent - base;
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.kind       = KIND_TICK;
    cmd_ch.write_data = '0;
    cmd_ch.send_ack   = 1'b0;
    cmd_ch.sda_sample = 1'b1;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_PHASE_TICKS;
    cfg_ch.data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_lines();
    test_bus_frames();
    test_write_byte();
    test_read_byte();
    test_busy_commands();
    test_register_extremes();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && line_status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: i2c_master_byte_engine.f
rtl/i2cm_pkg.sv
rtl/i2cm_cmd_if.sv
rtl/i2cm_rsp_if.sv
rtl/i2cm_cfg_if.sv
rtl/i2cm_step.sv
rtl/i2c_master_byte_engine.sv
dv/tb_top.sv
